// ===== rtl/core/phs_pkg.sv =====
// Shared types and constants for the periodic 1-D heat stencil block.
// Used by phs_grid_ram, phs_update and periodic_heat_stencil_1d.
// No dependencies.
`default_nettype none

package phs_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = IDX_W + 1;
  localparam int DEPTH      = 2 * MAX_POINTS;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int RATIO_W    = 17;
  localparam int LEN_W      = 11;
  localparam int STEP_W     = 16;
  localparam int PIDX_W     = 10;
  localparam int LAP_W      = DATA_W + 3;
  localparam int PROD_W     = LAP_W + RATIO_W + 1;
  localparam int QUOT_W     = PROD_W - FRAC_W;
  localparam int SUM_W      = QUOT_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATIO = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0]   RING_LENGTH_RST     = LEN_W'(100);
  localparam logic [RATIO_W-1:0] DIFFUSION_RATIO_RST = RATIO_W'(32768);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // One word from the grid memory heading into the stencil unit
  typedef struct packed {
    logic              vld;
    logic              pt;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } strm_t;

  // Updated point leaving the stencil unit
  typedef struct packed {
    logic              vld;
    logic              busy;
    logic              sat;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } upd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/phs_grid_ram.sv =====
// Two-bank grid memory: one write port, one read port with registered data.
// Depends on phs_pkg.
`default_nettype none

module phs_grid_ram (
  input  logic                           clk,
  input  phs_pkg::ram_wr_t               wr,
  input  phs_pkg::ram_rd_t               rd,
  output logic [phs_pkg::DATA_W-1:0]     rdata
);
  import phs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phs_update.sv =====
// Shared stencil unit: sliding window, Laplacian times ratio, add and saturate.
// Depends on phs_pkg.
`default_nettype none

module phs_update (
  input  logic                         clk,
  input  logic                         rst_n,
  input  phs_pkg::strm_t               strm,
  input  logic [phs_pkg::RATIO_W-1:0]  ratio,
  output phs_pkg::upd_t                res
);
  import phs_pkg::*;

  logic signed [DATA_W-1:0] win_l_r, win_m_r, win_rt_r;
  logic                     win_vld_r;
  logic [IDX_W-1:0]         win_idx_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [DATA_W-1:0] mid_r;
  logic                     prod_vld_r;
  logic [IDX_W-1:0]         prod_idx_r;

  logic signed [LAP_W-1:0]   lap;
  logic signed [RATIO_W:0]   ratio_s;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [SUM_W-1:0]   sum;
  logic                      sat_hi, sat_lo;

  always_comb begin
    lap      = LAP_W'(win_l_r) - (LAP_W'(win_m_r) <<< 1) + LAP_W'(win_rt_r);
    ratio_s  = $signed({1'b0, ratio});
    prod_nxt = PROD_W'(lap) * PROD_W'(ratio_s);
  end

  // Floor shift is the top bits of the product
  always_comb begin
    quot   = prod_r[PROD_W-1:FRAC_W];
    sum    = SUM_W'(mid_r) + SUM_W'(quot);
    sat_hi = !sum[SUM_W-1] && (|sum[SUM_W-1:DATA_W-1]);
    sat_lo = sum[SUM_W-1] && !(&sum[SUM_W-1:DATA_W-1]);
  end

  always_comb begin
    res.vld  = prod_vld_r;
    res.busy = win_vld_r || prod_vld_r;
    res.sat  = sat_hi || sat_lo;
    res.idx  = prod_idx_r;
    if (sat_hi) begin
      res.value = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (sat_lo) begin
      res.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.value = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      win_vld_r  <= strm.vld && strm.pt;
      prod_vld_r <= win_vld_r;
    end
    // Shift the window on every word that arrives
    if (strm.vld) begin
      win_l_r   <= win_m_r;
      win_m_r   <= win_rt_r;
      win_rt_r  <= $signed(strm.data);
      win_idx_r <= strm.idx;
    end
    prod_r     <= prod_nxt;
    mid_r      <= win_m_r;
    prod_idx_r <= win_idx_r;
  end

endmodule

`default_nettype wire

// ===== rtl/core/periodic_heat_stencil_1d.sv =====
// Periodic 1-D explicit heat stencil: a ring of signed Q16.16 points in two
// memory banks, advanced by new = m + ((l - 2m + rt) * r) >>> 16 with saturation.
// Depends on phs_pkg, phs_grid_ram and phs_update.
`default_nettype none

// One item is taken at a time and gives exactly one result. In a run, the
// single grid memory read port streams one point a cycle through one shared
// multiply-add unit, and each step drains that unit before the banks swap.
// The result waits in an output register, so the next item may be taken while
// it is still unread. Grid points are undefined until an init ramp or write
// sets them; there is no clearing pass after reset.
module periodic_heat_stencil_1d (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [phs_pkg::PIDX_W-1:0]       in_point_index,
  input  logic signed [phs_pkg::DATA_W-1:0] in_point_value,
  input  logic [phs_pkg::STEP_W-1:0]       in_step_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [phs_pkg::DATA_W-1:0] out_read_value,
  output logic                             out_saturated,
  input  logic                             cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [phs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import phs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_WR, ST_RD, ST_RDW, ST_ISSUE, ST_DRAIN, ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic [DATA_W-1:0]  pval_r, pval_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               bank_r, bank_nxt;
  logic               sat_r, sat_nxt;
  logic [DATA_W-1:0]  res_val_r, res_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_val_r, out_val_nxt;
  logic               out_sat_r, out_sat_nxt;
  logic               rtag_vld_r, rtag_vld_nxt;
  logic               rtag_pt_r, rtag_pt_nxt;
  logic [IDX_W-1:0]   rtag_idx_r, rtag_idx_nxt;
  logic [LEN_W-1:0]   ring_len_r, ring_len_nxt;
  logic [RATIO_W-1:0] ratio_r, ratio_nxt;

  logic [CNT_W-1:0]   n_eff;
  logic               idx_ok;
  logic [IDX_W-1:0]   rd_idx;
  logic [DATA_W-1:0]  ram_rdata;
  ram_wr_t            ram_wr;
  ram_rd_t            ram_rd;
  strm_t              strm;
  upd_t               upd;

  // Clamp the ring length into the legal range
  always_comb begin
    if (ring_len_r < LEN_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (CNT_W'(ring_len_r) > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(ring_len_r);
    end
  end

  assign idx_ok = {1'b0, pidx_r} < n_eff;

  // Read order per step: last point, then 0 .. n-1, then point 0 again
  always_comb begin
    if (cnt_r == '0) begin
      rd_idx = IDX_W'(n_eff - CNT_W'(1));
    end else if (cnt_r == n_eff + CNT_W'(1)) begin
      rd_idx = '0;
    end else begin
      rd_idx = IDX_W'(cnt_r - CNT_W'(1));
    end
  end

  always_comb begin
    ram_rd.re   = 1'b0;
    ram_rd.addr = {bank_r, pidx_r};
    if (state_r == ST_RD) begin
      ram_rd.re = idx_ok;
    end else if (state_r == ST_ISSUE) begin
      ram_rd.re   = 1'b1;
      ram_rd.addr = {bank_r, rd_idx};
    end
  end

  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = {bank_r, pidx_r};
    ram_wr.data = pval_r;
    if (upd.vld) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = {~bank_r, upd.idx};
      ram_wr.data = upd.value;
    end else if (state_r == ST_INIT) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = {bank_r, cnt_r[IDX_W-1:0]};
      ram_wr.data = DATA_W'({cnt_r, {FRAC_W{1'b0}}});
    end else if (state_r == ST_WR) begin
      ram_wr.we = idx_ok;
    end
  end

  always_comb begin
    strm.vld  = rtag_vld_r;
    strm.pt   = rtag_pt_r;
    strm.idx  = rtag_idx_r;
    strm.data = ram_rdata;
  end

  phs_grid_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  phs_update u_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .strm  (strm),
    .ratio (ratio_r),
    .res   (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pidx_nxt      = pidx_r;
    pval_nxt      = pval_r;
    steps_nxt     = steps_r;
    cnt_nxt       = cnt_r;
    bank_nxt      = bank_r;
    sat_nxt       = sat_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_sat_nxt   = out_sat_r;
    rtag_vld_nxt  = 1'b0;
    rtag_pt_nxt   = cnt_r >= CNT_W'(2);
    rtag_idx_nxt  = IDX_W'(cnt_r - CNT_W'(2));
    ring_len_nxt  = ring_len_r;
    ratio_nxt     = ratio_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_RING_LENGTH:     ring_len_nxt = cfg_wdata[LEN_W-1:0];
        REG_DIFFUSION_RATIO: ratio_nxt    = cfg_wdata[RATIO_W-1:0];
        default:             ;
      endcase
    end

    if (upd.vld && upd.sat) begin
      sat_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = op_t'(in_opcode);
          pidx_nxt    = in_point_index;
          pval_nxt    = in_point_value;
          steps_nxt   = in_step_count;
          cnt_nxt     = '0;
          sat_nxt     = 1'b0;
          res_val_nxt = '0;
          case (op_t'(in_opcode))
            OP_INIT:  state_nxt = ST_INIT;
            OP_WRITE: state_nxt = ST_WR;
            OP_READ:  state_nxt = ST_RD;
            OP_RUN:   state_nxt = (in_step_count == '0) ? ST_DONE : ST_ISSUE;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INIT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == n_eff - CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WR: state_nxt = ST_DONE;
      ST_RD: state_nxt = ST_RDW;
      ST_RDW: begin
        res_val_nxt = idx_ok ? ram_rdata : '0;
        state_nxt   = ST_DONE;
      end
      ST_ISSUE: begin
        rtag_vld_nxt = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == n_eff + CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Swap banks only once the last update has been written
        if (!rtag_vld_r && !upd.busy) begin
          bank_nxt  = ~bank_r;
          steps_nxt = steps_r - STEP_W'(1);
          cnt_nxt   = '0;
          state_nxt = (steps_r == STEP_W'(1)) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rtag_vld_r  <= 1'b0;
      ring_len_r  <= RING_LENGTH_RST;
      ratio_r     <= DIFFUSION_RATIO_RST;
      op_r        <= OP_INIT;
      cnt_r       <= '0;
      steps_r     <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      rtag_vld_r  <= rtag_vld_nxt;
      ring_len_r  <= ring_len_nxt;
      ratio_r     <= ratio_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
      sat_r       <= sat_nxt;
    end
    pidx_r     <= pidx_nxt;
    pval_r     <= pval_nxt;
    res_val_r  <= res_val_nxt;
    out_val_r  <= out_val_nxt;
    out_sat_r  <= out_sat_nxt;
    rtag_pt_r  <= rtag_pt_nxt;
    rtag_idx_r <= rtag_idx_nxt;
  end

  assign in_ready       = state_r == ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_read_value = $signed(out_val_r);
  assign out_saturated  = out_sat_r;

`ifndef NO_ASSERTIONS
  // Updates always land in the bank that is not being read
  a_upd_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
    upd.vld |-> (ram_wr.addr[ADDR_W-1] != bank_r))
    else $error("stencil update written into the active bank");

  // Memory words reach the stencil unit only during a run
  a_strm_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    strm.vld |-> (state_r == ST_ISSUE || state_r == ST_DRAIN))
    else $error("stencil stream word outside a run");

  // Banks swap only at the end of a drained step
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && bank_r != $past(bank_r)) |-> ($past(state_r) == ST_DRAIN))
    else $error("bank swapped outside step end");

  // Only a run may report saturation
  a_sat_run_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r != OP_RUN) |-> !sat_r)
    else $error("saturation flagged on a non-run item");
`endif

endmodule

`default_nettype wire

// ===== tb/periodic_heat_stencil_1d_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for periodic_heat_stencil_1d: random and directed grid
// commands with a cycle-free model of the ring checked against every result.
// Depends on phs_pkg and the periodic_heat_stencil_1d RTL.

module periodic_heat_stencil_1d_tb;
  import phs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  // slowest item: 65535 steps over a ring of two
  localparam int WATCHDOG_LIMIT = 2_000_000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    op_t                op;
    logic [PIDX_W-1:0]  pidx;
    logic [DATA_W-1:0]  pval;
    logic [STEP_W-1:0]  steps;
  } grid_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              is_run;
  } grid_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [PIDX_W-1:0] in_point_index = '0;
  logic signed [DATA_W-1:0] in_point_value = '0;
  logic [STEP_W-1:0] in_step_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic out_saturated;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // ring model
  logic [DATA_W-1:0] grid_model [0:DEPTH-1];
  logic bank_sel = 1'b0;
  logic [LEN_W-1:0] ring_len_reg = RING_LENGTH_RST;
  logic [RATIO_W-1:0] ratio_reg = DIFFUSION_RATIO_RST;

  grid_cmd_t cmd_backlog[$];
  grid_reply_t grid_replies[$];

  int items_issued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int runs_seen = 0;
  int sat_runs = 0;
  int settings_used = 1;
  int covered = 0;      // leading points of the active bank known to be written
  int idle_pct = 0;
  int stall_pct = 0;
  bit steady_tail = 1'b0;
  bit in_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int stuck_cycles = 0;

  periodic_heat_stencil_1d i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_point_index (in_point_index),
    .in_point_value (in_point_value),
    .in_step_count  (in_step_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_saturated  (out_saturated),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_len();
    int n;
    n = ring_len_reg;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  function automatic logic [DATA_W-1:0] heat_point(logic [DATA_W-1:0] l,
                                                   logic [DATA_W-1:0] m,
                                                   logic [DATA_W-1:0] rt,
                                                   ref logic sat);
    longint lap;
    longint v;
    lap = longint'($signed(l)) - 2 * longint'($signed(m)) + longint'($signed(rt));
    v = longint'($signed(m)) + ((lap * longint'(ratio_reg)) >>> FRAC_W);
    if (v > Q_MAX) begin
      v = Q_MAX;
      sat = 1'b1;
    end
    if (v < Q_MIN) begin
      v = Q_MIN;
      sat = 1'b1;
    end
    return v[DATA_W-1:0];
  endfunction

  // advance the ring model by one command and return its result item
  function automatic grid_reply_t step_grid(grid_cmd_t c);
    grid_reply_t r;
    int n;
    int cur;
    int nxt;
    int li;
    int ri;
    logic sat;
    sat = 1'b0;
    r = '0;
    r.is_run = (c.op == OP_RUN);
    n = eff_len();
    cur = bank_sel ? MAX_POINTS : 0;
    case (c.op)
      OP_INIT: begin
        for (int i = 0; i < n; i++) grid_model[cur + i] = DATA_W'(i) << FRAC_W;
      end
      OP_WRITE: begin
        if (c.pidx < n) grid_model[cur + c.pidx] = c.pval;
      end
      OP_READ: begin
        if (c.pidx < n) r.value = grid_model[cur + c.pidx];
      end
      default: begin
        for (int t = 0; t < c.steps; t++) begin
          cur = bank_sel ? MAX_POINTS : 0;
          nxt = MAX_POINTS - cur;
          for (int i = 0; i < n; i++) begin
            li = (i == 0) ? n - 1 : i - 1;
            ri = (i == n - 1) ? 0 : i + 1;
            grid_model[nxt + i] = heat_point(grid_model[cur + li], grid_model[cur + i],
                                             grid_model[cur + ri], sat);
          end
          bank_sel = ~bank_sel;
        end
      end
    endcase
    r.sat = sat;
    return r;
  endfunction

  // unused fields carry random bits so that every input bit toggles
  task automatic issue(op_t op, int pidx, logic [DATA_W-1:0] val, int steps);
    grid_cmd_t c;
    int n;
    n = eff_len();
    c.op = op;
    c.pidx = PIDX_W'($urandom);
    c.pval = $urandom;
    c.steps = STEP_W'($urandom);
    case (op)
      OP_INIT: begin
        if (covered < n) covered = n;
      end
      OP_WRITE: begin
        c.pidx = PIDX_W'(pidx);
        c.pval = val;
      end
      OP_READ: begin
        c.pidx = PIDX_W'(pidx);
      end
      default: begin
        c.steps = STEP_W'(steps);
        if (steps > 0) covered = n;
      end
    endcase
    cmd_backlog.push_back(c);
    items_issued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_RING_LENGTH:     ring_len_reg = data[LEN_W-1:0];
      REG_DIFFUSION_RATIO: ratio_reg = data[RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (results_seen != items_issued) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(int n);
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4, 5, 6: return (DATA_W'($urandom_range(0, 2 * n) - n) << FRAC_W)
                      ^ DATA_W'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(int n);
    if ($urandom_range(99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, MAX_POINTS - 1);
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] ratio_word;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) len_word = CFG_DATA_W'($urandom_range(2, 16));
    else if (pick < 70) len_word = CFG_DATA_W'($urandom_range(17, 128));
    else if (pick < 80) len_word = CFG_DATA_W'($urandom_range(129, 1024));
    else if (pick < 90) len_word = CFG_DATA_W'($urandom_range(0, 2047));
    else begin
      case ($urandom_range(5))
        0: len_word = 0;
        1: len_word = 1;
        2: len_word = 2;
        3: len_word = 1024;
        4: len_word = 1025;
        default: len_word = 2047;
      endcase
    end
    // bits above the register width are dropped
    if ($urandom_range(3) == 0) len_word[CFG_DATA_W-1:LEN_W] = (CFG_DATA_W-LEN_W)'($urandom);
    case ($urandom_range(7))
      0: ratio_word = 0;
      1: ratio_word = 131071;
      2: ratio_word = 65536;
      3: ratio_word = 1;
      default: ratio_word = CFG_DATA_W'($urandom_range(0, 131071));
    endcase
    write_reg(REG_RING_LENGTH, len_word);
    write_reg(REG_DIFFUSION_RATIO, ratio_word);
    if ($urandom_range(3) == 0) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                          CFG_DATA_W'($urandom));
    settings_used++;
  endtask

  task automatic random_items(int count);
    int n;
    int pick;
    int limit;
    int steps;
    for (int k = 0; k < count; k++) begin
      n = eff_len();
      pick = $urandom_range(99);
      if (pick < 6) begin
        issue(OP_INIT, 0, '0, 0);
      end else if (pick < 36) begin
        issue(OP_WRITE, pick_index(n), pick_value(n), 0);
      end else if (pick < 70) begin
        if (covered < n) issue(OP_INIT, 0, '0, 0);
        issue(OP_READ, pick_index(n), '0, 0);
      end else begin
        limit = 2000 / (n + 6);
        if (limit < 1) limit = 1;
        if (limit > 24) limit = 24;
        steps = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, limit);
        if (steps > 0 && covered < n) issue(OP_INIT, 0, '0, 0);
        issue(OP_RUN, 0, '0, steps);
      end
    end
  endtask

  // driver: present items from the backlog, with bursts of idle cycles
  always @(negedge clk) begin
    grid_cmd_t c;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0) begin
        if (!steady_tail && $urandom_range(99) < idle_pct) begin
          gap_left = $urandom_range(1, 18) - 1;
        end else begin
          c = cmd_backlog.pop_front();
          nxt_valid = 1'b1;
          in_opcode <= c.op;
          in_point_index <= c.pidx;
          in_point_value <= c.pval;
          in_step_count <= c.steps;
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!steady_tail && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    grid_reply_t want;
    grid_cmd_t got;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (grid_replies.size() == 0) begin
          $error("result item with nothing outstanding: read_value %0d saturated %0b",
                 out_read_value, out_saturated);
          fail_count++;
        end else begin
          want = grid_replies.pop_front();
          if (out_read_value !== want.value) begin
            $error("read_value: expected %0d, actual %0d", $signed(want.value),
                   out_read_value);
            fail_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, out_saturated);
            fail_count++;
          end
          if (want.is_run) begin
            runs_seen++;
            if (want.sat) sat_runs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        got.op = op_t'(in_opcode);
        got.pidx = in_point_index;
        got.pval = in_point_value;
        got.steps = in_step_count;
        grid_replies.push_back(step_grid(got));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("periodic_heat_stencil_1d: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: ramp, extremes, out-of-ring access, zero and single step
    idle_pct = 20;
    stall_pct = 20;
    issue(OP_INIT, 0, '0, 0);
    issue(OP_READ, 0, '0, 0);
    issue(OP_READ, 99, '0, 0);
    issue(OP_READ, 100, '0, 0);
    issue(OP_WRITE, 5, 32'h7FFF_FFFF, 0);
    issue(OP_WRITE, 6, 32'h8000_0000, 0);
    issue(OP_WRITE, 1023, 32'h1234_5678, 0);
    issue(OP_READ, 1023, '0, 0);
    issue(OP_READ, 5, '0, 0);
    issue(OP_RUN, 0, '0, 0);
    issue(OP_RUN, 0, '0, 1);
    issue(OP_READ, 6, '0, 0);
    settle();

    // smallest ring at the largest ratio: saturate, then the longest run
    write_reg(REG_RING_LENGTH, 2);
    write_reg(REG_DIFFUSION_RATIO, 131071);
    settings_used++;
    issue(OP_INIT, 0, '0, 0);
    issue(OP_WRITE, 0, 32'h7FFF_FFFF, 0);
    issue(OP_WRITE, 1, 32'h8000_0000, 0);
    issue(OP_RUN, 0, '0, 1);
    issue(OP_READ, 0, '0, 0);
    issue(OP_RUN, 0, '0, 65535);
    issue(OP_READ, 1, '0, 0);
    settle();

    // oversized length clamps to the full ring; zero ratio holds the values
    write_reg(REG_RING_LENGTH, 2047);
    write_reg(REG_DIFFUSION_RATIO, 0);
    settings_used++;
    issue(OP_INIT, 0, '0, 0);
    issue(OP_RUN, 0, '0, 2);
    issue(OP_READ, 1023, '0, 0);
    settle();

    // full ring with junk above the length field, unit ratio: wrap at point zero
    write_reg(REG_RING_LENGTH, 17'h1F400);
    write_reg(REG_DIFFUSION_RATIO, 65536);
    settings_used++;
    issue(OP_RUN, 0, '0, 1);
    issue(OP_READ, 0, '0, 0);
    settle();

    // zero length acts as two; registers past the list are dropped
    write_reg(REG_RING_LENGTH, 0);
    write_reg(REG_SPARE_A, 17'h1FFFF);
    write_reg(REG_SPARE_B, 17'h00001);
    settings_used++;
    issue(OP_WRITE, 1, '1, 0);
    issue(OP_READ, 1, '0, 0);
    issue(OP_READ, 2, '0, 0);
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 30;
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase
      if (phase == 9) steady_tail = 1'b1;
      random_items(40);
      settle();
    end

    repeat (16) @(negedge clk);
    $display("ran %0d items over %0d register settings", items_issued, settings_used);
    $display("%0d runs checked, %0d of them saturated", runs_seen, sat_runs);
    if (fail_count == 0 && grid_replies.size() == 0) begin
      $display("periodic_heat_stencil_1d: match");
    end else begin
      $display("periodic_heat_stencil_1d: mismatch");
    end
    $finish;
  end

endmodule
